// ===== src/qwmi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qwmi_pkg
// Constants, types and helpers shared by the middle-insert queue.
// ----------------------------------------------------------------------------
package qwmi_pkg;

   localparam int QUEUE_DEPTH = 1024;
   localparam int HALF_DEPTH  = (QUEUE_DEPTH + 1) / 2;
   localparam int ADDR_W      = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
   localparam int FILL_W      = $clog2(HALF_DEPTH + 1);

   localparam logic [1:0] OP_PUSH_BACK = 2'd0;
   localparam logic [1:0] OP_PUSH_MID  = 2'd1;
   localparam logic [1:0] OP_POP       = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef logic signed [31:0] value_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [FILL_W-1:0]  fill_type;

   // Memory accesses and pointer updates for one transaction
   typedef struct packed {
      logic        fr_rd;
      addr_type    fr_rd_addr;
      logic        fr_wr;
      addr_type    fr_wr_addr;
      logic        fr_wr_move;
      logic        br_rd;
      addr_type    br_rd_addr;
      logic        br_wr;
      addr_type    br_wr_addr;
      logic        rsp_en;
      logic [1:0]  status;
      logic        pop;
      addr_type    fh_next;
      fill_type    ff_next;
      addr_type    bh_next;
      fill_type    bf_next;
      fill_type    ff_now;
      fill_type    bf_now;
   } plan_type;

   function automatic addr_type wrap_add(input addr_type addr, input fill_type fill);
      logic [FILL_W:0] sum;
      sum = (FILL_W+1)'(addr) + {1'b0, fill};
      if (sum >= (FILL_W+1)'(HALF_DEPTH)) begin
         sum = sum - (FILL_W+1)'(HALF_DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

   function automatic addr_type wrap_inc(input addr_type addr);
      return (addr == ADDR_W'(HALF_DEPTH - 1)) ? '0 : addr + 1'b1;
   endfunction

   function automatic addr_type wrap_dec(input addr_type addr);
      return (addr == '0) ? ADDR_W'(HALF_DEPTH - 1) : addr - 1'b1;
   endfunction

endpackage
`default_nettype wire

// ===== src/qwmi_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qwmi_req_if / qwmi_rsp_if
// Valid/ready channels for queue commands and queue results.
// ----------------------------------------------------------------------------
interface qwmi_req_if;
   import qwmi_pkg::*;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   value_type  push_value;

   modport source (output valid, output opcode, output push_value, input ready);
   modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface qwmi_rsp_if;
   import qwmi_pkg::*;
   logic       valid;
   logic       ready;
   value_type  popped_value;
   logic [1:0] status;

   modport source (output valid, output popped_value, output status, input ready);
   modport sink   (input valid, input popped_value, input status, output ready);
endinterface
`default_nettype wire

// ===== src/qwmi_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qwmi_ram
// One ring of the queue: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module qwmi_ram (
   input  wire                logic clock,
   input  wire                logic wr_en,
   input  wire qwmi_pkg::addr_type  wr_addr,
   input  wire qwmi_pkg::value_type wr_data,
   input  wire                logic rd_en,
   input  wire qwmi_pkg::addr_type  rd_addr,
   output      qwmi_pkg::value_type rd_data
);
   import qwmi_pkg::*;

   value_type mem [HALF_DEPTH];
   value_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== src/qwmi_ptr.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qwmi_ptr
// Ring head and fill registers, and the access plan for the next command.
// ----------------------------------------------------------------------------
module qwmi_ptr (
   input  wire                 logic clock,
   input  wire                 logic reset,
   input  wire                 logic [1:0] opcode,
   input  wire                 logic commit,
   input  wire qwmi_pkg::plan_type   commit_plan,
   output      qwmi_pkg::plan_type   plan
);
   import qwmi_pkg::*;

   addr_type fh_ff, bh_ff;
   fill_type ff_ff, bf_ff;
   logic     full;
   logic     even;

   always_ff @(posedge clock) begin
      if (reset) begin
         fh_ff <= '0;
         ff_ff <= '0;
         bh_ff <= '0;
         bf_ff <= '0;
      end else if (commit) begin
         fh_ff <= commit_plan.fh_next;
         ff_ff <= commit_plan.ff_next;
         bh_ff <= commit_plan.bh_next;
         bf_ff <= commit_plan.bf_next;
      end
   end

   assign full = ({1'b0, ff_ff} + {1'b0, bf_ff}) >= (FILL_W+1)'(QUEUE_DEPTH);
   assign even = (ff_ff == bf_ff);

   always_comb begin
      plan            = '0;
      plan.fh_next    = fh_ff;
      plan.ff_next    = ff_ff;
      plan.bh_next    = bh_ff;
      plan.bf_next    = bf_ff;
      plan.ff_now     = ff_ff;
      plan.bf_now     = bf_ff;
      plan.fr_rd_addr = fh_ff;
      plan.fr_wr_addr = wrap_add(fh_ff, ff_ff);
      plan.br_rd_addr = bh_ff;
      plan.br_wr_addr = wrap_add(bh_ff, bf_ff);
      plan.status     = ST_OK;
      case (opcode)
         OP_PUSH_BACK: begin
            if (full) begin
               plan.rsp_en = 1'b1;
               plan.status = ST_FULL;
            end else if (even && bf_ff == '0) begin
               plan.fr_wr   = 1'b1;
               plan.ff_next = ff_ff + 1'b1;
            end else if (even) begin
               // shift the back head into the front, then append to the back
               plan.br_rd      = 1'b1;
               plan.fr_wr      = 1'b1;
               plan.fr_wr_move = 1'b1;
               plan.br_wr      = 1'b1;
               plan.bh_next    = wrap_inc(bh_ff);
               plan.ff_next    = ff_ff + 1'b1;
            end else begin
               plan.br_wr   = 1'b1;
               plan.bf_next = bf_ff + 1'b1;
            end
         end
         OP_PUSH_MID: begin
            if (full) begin
               plan.rsp_en = 1'b1;
               plan.status = ST_FULL;
            end else if (even) begin
               plan.fr_wr   = 1'b1;
               plan.ff_next = ff_ff + 1'b1;
            end else begin
               plan.br_wr      = 1'b1;
               plan.br_wr_addr = wrap_dec(bh_ff);
               plan.bh_next    = wrap_dec(bh_ff);
               plan.bf_next    = bf_ff + 1'b1;
            end
         end
         OP_POP: begin
            plan.rsp_en = 1'b1;
            if (ff_ff == '0) begin
               plan.status = ST_EMPTY;
            end else begin
               plan.pop     = 1'b1;
               plan.fr_rd   = 1'b1;
               plan.fh_next = wrap_inc(fh_ff);
               if ((ff_ff - 1'b1) < bf_ff) begin
                  // rebalance: front count stays, back head moves over
                  plan.br_rd      = 1'b1;
                  plan.fr_wr      = 1'b1;
                  plan.fr_wr_move = 1'b1;
                  plan.bh_next    = wrap_inc(bh_ff);
                  plan.bf_next    = bf_ff - 1'b1;
               end else begin
                  plan.ff_next = ff_ff - 1'b1;
               end
            end
         end
         default: begin
            plan.rsp_en = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== src/queue_with_middle_insert.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// queue_with_middle_insert
// Bounded queue of signed 32-bit values with push back, push middle and pop.
// ----------------------------------------------------------------------------
// Commands enter on req (opcode, push_value); results leave on rsp
// (popped_value, status). A transaction moves when valid and ready are high.
// A successful push and opcode 3 give no result; a pop gives one result, and
// a push on a full queue gives one with status full and value zero.
// Each command is a read step then a write step: in the first the ring
// reads are issued from the head registers, in the second the read data
// returns and the writes and pointer updates are done; the synchronous read
// of each ring sets this. A result appears on rsp the cycle after the second
// step. req.ready is low until a command finishes; one runs at a time.
// The result register holds while rsp.ready is low; a further command is
// still accepted and finishes unless it needs the result register too, in
// which case it waits in its second step until the result is taken.
// Reset empties both rings at once (head and fill registers only); ring
// contents are not cleared. req.ready stays low while reset is high.
// ----------------------------------------------------------------------------
module queue_with_middle_insert (
   input  wire logic clock,
   input  wire logic reset,
   qwmi_req_if.sink   req,
   qwmi_rsp_if.source rsp
);
   import qwmi_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic      state_ff, state_in;
   plan_type  plan, plan_ff;
   value_type value_ff;
   logic      accept, stall, advance;
   value_type fr_rd_data, br_rd_data, fr_wr_data;
   logic      out_valid_ff, out_valid_in;
   value_type out_value_ff;
   logic [1:0] out_status_ff;

   qwmi_ptr u_ptr (
      .clock       (clock),
      .reset       (reset),
      .opcode      (req.opcode),
      .commit      (advance),
      .commit_plan (plan_ff),
      .plan        (plan)
   );

   assign req.ready = !reset && (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   assign stall     = plan_ff.rsp_en && out_valid_ff && !rsp.ready;
   assign advance   = (state_ff == S_EXEC) && !stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept) state_in = S_EXEC;
         S_EXEC:  if (advance) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         plan_ff  <= plan;
         value_ff <= req.push_value;
      end
   end

   assign fr_wr_data = plan_ff.fr_wr_move ? br_rd_data : value_ff;

   qwmi_ram u_front (
      .clock   (clock),
      .wr_en   (advance && plan_ff.fr_wr),
      .wr_addr (plan_ff.fr_wr_addr),
      .wr_data (fr_wr_data),
      .rd_en   (accept && plan.fr_rd),
      .rd_addr (plan.fr_rd_addr),
      .rd_data (fr_rd_data)
   );

   qwmi_ram u_back (
      .clock   (clock),
      .wr_en   (advance && plan_ff.br_wr),
      .wr_addr (plan_ff.br_wr_addr),
      .wr_data (value_ff),
      .rd_en   (accept && plan.br_rd),
      .rd_addr (plan.br_rd_addr),
      .rd_data (br_rd_data)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance && plan_ff.rsp_en) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && plan_ff.rsp_en) begin
         out_value_ff  <= plan_ff.pop ? fr_rd_data : '0;
         out_status_ff <= plan_ff.status;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.popped_value = out_value_ff;
   assign rsp.status       = out_status_ff;

`ifndef SYNTHESIS
   a_balance: assert property (@(posedge clock) disable iff (reset)
      (plan.ff_now == plan.bf_now) || (plan.ff_now == plan.bf_now + 1'b1))
      else $error("ring fill counts out of balance");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req.ready)
      else $error("command accepted while another is in progress");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status != ST_OK) |-> (rsp.popped_value == '0))
      else $error("error result carries a nonzero value");

   a_back_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (accept && plan.br_rd && plan.br_wr) |-> (plan.br_rd_addr != plan.br_wr_addr))
      else $error("back ring read and write hit the same entry");
`endif

endmodule
`default_nettype wire
